// ===== rtl/snrt_pkg.sv =====
// ----------------------------------------------------------------------------
// snrt_pkg
// Shared constants, types and codes of the stream name route table.
// ----------------------------------------------------------------------------
package snrt_pkg;

    localparam int SLOT_COUNT     = 64;
    localparam int MAX_ROUTES     = 32;
    localparam int MAX_NAME_BYTES = 64;

    localparam int SLOT_W   = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
    localparam int ROUTE_AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int KEY_AW   = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
    localparam int CNT_W    = $clog2(MAX_NAME_BYTES + 1);
    localparam int NAME_AW  = ROUTE_AW + KEY_AW;

    localparam int STATUS_W = 3;
    localparam int ROUTE_W  = 5;
    localparam int BYTE_W   = 8;

    // Only the low SLOT_W bits of the FNV-1a hash pick the start slot, and
    // those bits of an xor and a product depend on the low bits alone.
    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

    typedef logic [SLOT_W-1:0]  t_hash;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [KEY_AW-1:0]  t_key_addr;
    typedef logic [ROUTE_W-1:0] t_route;

    localparam t_hash HASH_BASIS = t_hash'(FNV_BASIS);
    localparam t_hash HASH_PRIME = t_hash'(FNV_PRIME);

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_UNKNOWN   = 3'd1,
        ST_TOO_LONG  = 3'd2,
        ST_INSERTED  = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_ACCEPT,
        S_PROBE,
        S_SLOTRD,
        S_LENRD,
        S_CMP,
        S_COPY,
        S_DONE
    } t_state;

    // Name state after the current byte is taken in.
    typedef struct packed {
        t_hash  hash;
        t_count len;
        logic   too_long;
    } t_key_info;

endpackage

// ===== rtl/snrt_if.sv =====
// ----------------------------------------------------------------------------
// snrt_req_if / snrt_rsp_if
// Valid/ready channels for name bytes and route table answers.
// ----------------------------------------------------------------------------
interface snrt_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [snrt_pkg::BYTE_W-1:0] name_byte;
    logic                        last;
    logic [snrt_pkg::ROUTE_W-1:0] entry_index;

    modport source (output valid, command, name_byte, last, entry_index, input ready);
    modport sink   (input valid, command, name_byte, last, entry_index, output ready);
endinterface

interface snrt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [snrt_pkg::STATUS_W-1:0] status;
    logic [snrt_pkg::ROUTE_W-1:0]  route_id;

    modport source (output valid, status, route_id, input ready);
    modport sink   (input valid, status, route_id, output ready);
endinterface

// ===== rtl/snrt_front.sv =====
// ----------------------------------------------------------------------------
// snrt_front
// Byte intake: running hash, byte count, too-long flag and key buffer.
// ----------------------------------------------------------------------------
module snrt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [snrt_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_last,
    input  snrt_pkg::t_key_addr         i_rd_addr,
    output logic [snrt_pkg::BYTE_W-1:0] o_rd_data,
    output snrt_pkg::t_key_info         o_info
);

    logic [snrt_pkg::BYTE_W-1:0] r_key [snrt_pkg::MAX_NAME_BYTES];
    snrt_pkg::t_hash  r_hash, n_hash, w_mix;
    snrt_pkg::t_count r_cnt,  n_cnt;
    logic             r_too,  n_too;
    logic             w_room;

    assign w_room = (r_cnt < snrt_pkg::t_count'(snrt_pkg::MAX_NAME_BYTES));
    assign w_mix  = r_hash ^ snrt_pkg::t_hash'(i_byte);
    assign n_hash = snrt_pkg::t_hash'(w_mix * snrt_pkg::HASH_PRIME);
    assign n_cnt  = w_room ? r_cnt + snrt_pkg::t_count'(1) : r_cnt;
    assign n_too  = r_too | ~w_room;

    assign o_info = '{hash: n_hash, len: n_cnt, too_long: n_too};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= snrt_pkg::HASH_BASIS;
            r_cnt  <= '0;
            r_too  <= 1'b0;
        end else if (i_we) begin
            // clear back to the empty name after the final byte
            r_hash <= i_last ? snrt_pkg::HASH_BASIS : n_hash;
            r_cnt  <= i_last ? '0 : n_cnt;
            r_too  <= i_last ? 1'b0 : n_too;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && w_room) begin
            r_key[r_cnt[snrt_pkg::KEY_AW-1:0]] <= i_byte;
        end
        o_rd_data <= r_key[i_rd_addr];
    end

endmodule

// ===== rtl/snrt_slots.sv =====
// ----------------------------------------------------------------------------
// snrt_slots
// Slot table: valid flags in flops, route indexes in a synchronous memory.
// ----------------------------------------------------------------------------
module snrt_slots (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  snrt_pkg::t_hash             i_addr,
    input  snrt_pkg::t_route            i_wr_route,
    output logic                        o_valid,
    output snrt_pkg::t_route            o_rd_route
);

    logic             r_valid [snrt_pkg::SLOT_COUNT];
    snrt_pkg::t_route r_route [snrt_pkg::SLOT_COUNT];

    assign o_valid = r_valid[i_addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < snrt_pkg::SLOT_COUNT; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (i_we) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_route[i_addr] <= i_wr_route;
        end
        o_rd_route <= r_route[i_addr];
    end

endmodule

// ===== rtl/snrt_names.sv =====
// ----------------------------------------------------------------------------
// snrt_names
// Stored names and their lengths, one row per route index.
// ----------------------------------------------------------------------------
module snrt_names (
    input  logic                          i_clk,
    input  logic                          i_name_we,
    input  logic [snrt_pkg::NAME_AW-1:0]  i_name_wr_addr,
    input  logic [snrt_pkg::BYTE_W-1:0]   i_name_wr_data,
    input  logic [snrt_pkg::NAME_AW-1:0]  i_name_rd_addr,
    output logic [snrt_pkg::BYTE_W-1:0]   o_name_rd_data,
    input  logic                          i_len_we,
    input  logic [snrt_pkg::ROUTE_AW-1:0] i_len_wr_addr,
    input  snrt_pkg::t_count              i_len_wr_data,
    input  logic [snrt_pkg::ROUTE_AW-1:0] i_len_rd_addr,
    output snrt_pkg::t_count              o_len_rd_data
);

    logic [snrt_pkg::BYTE_W-1:0] r_name [snrt_pkg::MAX_ROUTES * snrt_pkg::MAX_NAME_BYTES];
    snrt_pkg::t_count            r_len  [snrt_pkg::MAX_ROUTES];

    always_ff @(posedge i_clk) begin
        if (i_name_we) begin
            r_name[i_name_wr_addr] <= i_name_wr_data;
        end
        o_name_rd_data <= r_name[i_name_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_len_we) begin
            r_len[i_len_wr_addr] <= i_len_wr_data;
        end
        o_len_rd_data <= r_len[i_len_rd_addr];
    end

endmodule

// ===== rtl/stream_name_hash_route_table_top.sv =====
// ----------------------------------------------------------------------------
// stream_name_hash_route_table_top
// Route table keyed by stream names, with hashed linear probing.
// ----------------------------------------------------------------------------
// A name arrives one byte per request, the final byte flagged by last; each
// byte advances the FNV-1a hash and key buffer. After the final byte the
// block stops taking requests and, unless the name is too long or an insert's
// entry index is out of range, probes the slot table: a visit reads the slot's
// valid flag, an occupied slot then fetches its route and stored length, and a
// length match leads to a byte-by-byte compare. An insert that finds an empty
// slot copies the name into the name store at one byte per cycle. The answer
// goes to an output register, and the next name may start while it waits to
// be taken. The key buffer and name store set this byte-per-cycle pace. The
// slot valid flags are flops cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module stream_name_hash_route_table_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    snrt_req_if.sink   i_req,
    snrt_rsp_if.source o_rsp
);

    snrt_pkg::t_state    r_state, n_state;
    logic                r_cmd, n_cmd;
    snrt_pkg::t_route    r_entry, n_entry;
    snrt_pkg::t_route    r_route, n_route;
    snrt_pkg::t_hash     r_slot, n_slot;
    snrt_pkg::t_hash     r_probe, n_probe;
    snrt_pkg::t_count    r_len, n_len;
    snrt_pkg::t_key_addr r_idx, n_idx;
    snrt_pkg::t_status   r_res_status, n_res_status;
    snrt_pkg::t_route    r_res_route, n_res_route;
    logic                r_out_valid, n_out_valid;
    snrt_pkg::t_status   r_out_status, n_out_status;
    snrt_pkg::t_route    r_out_route, n_out_route;

    // intake
    logic                        w_front_we;
    snrt_pkg::t_key_addr         w_key_addr;
    logic [snrt_pkg::BYTE_W-1:0] w_key_data;
    snrt_pkg::t_key_info         w_info;
    // slots
    logic                        w_slot_we;
    logic                        w_slot_valid;
    snrt_pkg::t_route            w_slot_route;
    // names
    logic                          w_name_we;
    logic [snrt_pkg::NAME_AW-1:0]  w_name_wr_addr;
    logic [snrt_pkg::NAME_AW-1:0]  w_name_rd_addr;
    logic [snrt_pkg::BYTE_W-1:0]   w_name_data;
    logic                          w_len_we;
    logic [snrt_pkg::ROUTE_AW-1:0] w_len_rd_addr;
    snrt_pkg::t_count              w_len_data;

    snrt_pkg::t_key_addr w_last_idx;
    logic                w_last_probe;

    assign w_last_idx   = snrt_pkg::t_key_addr'(r_len - snrt_pkg::t_count'(1));
    assign w_last_probe = (r_probe == snrt_pkg::t_hash'(snrt_pkg::SLOT_COUNT - 1));

    snrt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (w_front_we),
        .i_byte    (i_req.name_byte),
        .i_last    (i_req.last),
        .i_rd_addr (w_key_addr),
        .o_rd_data (w_key_data),
        .o_info    (w_info)
    );

    snrt_slots u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (w_slot_we),
        .i_addr     (r_slot),
        .i_wr_route (r_entry),
        .o_valid    (w_slot_valid),
        .o_rd_route (w_slot_route)
    );

    snrt_names u_names (
        .i_clk          (i_clk),
        .i_name_we      (w_name_we),
        .i_name_wr_addr (w_name_wr_addr),
        .i_name_wr_data (w_key_data),
        .i_name_rd_addr (w_name_rd_addr),
        .o_name_rd_data (w_name_data),
        .i_len_we       (w_len_we),
        .i_len_wr_addr  (r_entry[snrt_pkg::ROUTE_AW-1:0]),
        .i_len_wr_data  (r_len),
        .i_len_rd_addr  (w_len_rd_addr),
        .o_len_rd_data  (w_len_data)
    );

    assign w_name_wr_addr = {r_entry[snrt_pkg::ROUTE_AW-1:0], r_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= snrt_pkg::S_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_entry      <= n_entry;
        r_route      <= n_route;
        r_slot       <= n_slot;
        r_probe      <= n_probe;
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_route  <= n_res_route;
        r_out_status <= n_out_status;
        r_out_route  <= n_out_route;
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_entry      = r_entry;
        n_route      = r_route;
        n_slot       = r_slot;
        n_probe      = r_probe;
        n_len        = r_len;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_route  = r_res_route;
        n_out_status = r_out_status;
        n_out_route  = r_out_route;
        // drop the answer once taken
        n_out_valid  = r_out_valid && !o_rsp.ready;

        i_req.ready    = 1'b0;
        w_front_we     = 1'b0;
        w_key_addr     = '0;
        w_slot_we      = 1'b0;
        w_name_we      = 1'b0;
        w_len_we       = 1'b0;
        w_name_rd_addr = {r_route[snrt_pkg::ROUTE_AW-1:0], r_idx};
        w_len_rd_addr  = r_route[snrt_pkg::ROUTE_AW-1:0];

        case (r_state)
            snrt_pkg::S_ACCEPT: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    w_front_we = 1'b1;
                    if (i_req.last) begin
                        n_cmd       = i_req.command;
                        n_entry     = i_req.entry_index;
                        n_len       = w_info.len;
                        n_slot      = w_info.hash;
                        n_probe     = '0;
                        n_res_route = '0;
                        if (w_info.too_long) begin
                            n_res_status = snrt_pkg::ST_TOO_LONG;
                            n_state      = snrt_pkg::S_DONE;
                        end else if (i_req.command == snrt_pkg::CMD_INSERT &&
                                     int'(i_req.entry_index) >= snrt_pkg::MAX_ROUTES) begin
                            n_res_status = snrt_pkg::ST_FULL;
                            n_state      = snrt_pkg::S_DONE;
                        end else begin
                            n_state = snrt_pkg::S_PROBE;
                        end
                    end
                end
            end

            snrt_pkg::S_PROBE: begin
                if (!w_slot_valid) begin
                    if (r_cmd == snrt_pkg::CMD_INSERT) begin
                        // claim the slot, then copy the key into the name store
                        w_slot_we = 1'b1;
                        w_len_we  = 1'b1;
                        n_idx     = '0;
                        n_state   = snrt_pkg::S_COPY;
                    end else begin
                        n_res_status = snrt_pkg::ST_UNKNOWN;
                        n_state      = snrt_pkg::S_DONE;
                    end
                end else begin
                    n_state = snrt_pkg::S_SLOTRD;
                end
            end

            snrt_pkg::S_SLOTRD: begin
                n_route       = w_slot_route;
                w_len_rd_addr = w_slot_route[snrt_pkg::ROUTE_AW-1:0];
                n_state       = snrt_pkg::S_LENRD;
            end

            snrt_pkg::S_LENRD, snrt_pkg::S_CMP: begin
                if ((r_state == snrt_pkg::S_LENRD && w_len_data != r_len) ||
                    (r_state == snrt_pkg::S_CMP && w_name_data != w_key_data)) begin
                    // mismatch: advance to the next slot, or end after the last probe
                    if (w_last_probe) begin
                        n_res_status = (r_cmd == snrt_pkg::CMD_INSERT) ?
                                       snrt_pkg::ST_FULL : snrt_pkg::ST_UNKNOWN;
                        n_state      = snrt_pkg::S_DONE;
                    end else begin
                        n_probe = r_probe + snrt_pkg::t_hash'(1);
                        n_slot  = r_slot + snrt_pkg::t_hash'(1);
                        n_state = snrt_pkg::S_PROBE;
                    end
                end else if (r_state == snrt_pkg::S_CMP && r_idx == w_last_idx) begin
                    if (r_cmd == snrt_pkg::CMD_INSERT) begin
                        n_res_status = snrt_pkg::ST_DUPLICATE;
                    end else begin
                        n_res_status = snrt_pkg::ST_FOUND;
                        n_res_route  = r_route;
                    end
                    n_state = snrt_pkg::S_DONE;
                end else begin
                    // fetch the next byte pair
                    n_idx          = (r_state == snrt_pkg::S_LENRD) ? '0 :
                                     r_idx + snrt_pkg::t_key_addr'(1);
                    w_key_addr     = n_idx;
                    w_name_rd_addr = {r_route[snrt_pkg::ROUTE_AW-1:0], n_idx};
                    n_state        = snrt_pkg::S_CMP;
                end
            end

            snrt_pkg::S_COPY: begin
                w_name_we = 1'b1;
                if (r_idx == w_last_idx) begin
                    n_res_status = snrt_pkg::ST_INSERTED;
                    n_res_route  = r_entry;
                    n_state      = snrt_pkg::S_DONE;
                end else begin
                    n_idx      = r_idx + snrt_pkg::t_key_addr'(1);
                    w_key_addr = n_idx;
                end
            end

            snrt_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_route  = r_res_route;
                    n_state      = snrt_pkg::S_ACCEPT;
                end
            end

            default: begin
                n_state = snrt_pkg::S_ACCEPT;
            end
        endcase
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.route_id = r_out_route;

    // A route index goes out only with a hit or a fresh insert.
    a_route_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.status != snrt_pkg::ST_FOUND &&
        o_rsp.status != snrt_pkg::ST_INSERTED |-> o_rsp.route_id == '0)
        else $error("route index set on a miss");

    // A claimed slot reads back as occupied once the block is in S_COPY.
    a_slot_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_slot_we |=> r_state == snrt_pkg::S_COPY && w_slot_valid)
        else $error("claimed slot not marked valid");

    // An answer is loaded only when the output register is free or drains.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == snrt_pkg::S_DONE && r_out_valid && !o_rsp.ready
        |=> r_state == snrt_pkg::S_DONE)
        else $error("answer overran the output register");

endmodule

// ===== verif/tb_stream_name_hash_route_table_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stream_name_hash_route_table_top
// Self-checking bench for the stream name route table.
// ----------------------------------------------------------------------------
// Drive names byte by byte into the block and keep a behavioral copy of the
// slot table, name store and running hash. Every final byte yields one
// predicted answer, queued in order and matched against the response channel.
// A directed table covers the reset state, name-length extremes, every status
// but ST_FULL and route index reuse; then random names follow, mostly reusing
// a small pool so that lookups hit and duplicates occur.
// ----------------------------------------------------------------------------
module tb_stream_name_hash_route_table_top;
    import snrt_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 20000;
    localparam int RANDOM_NAMES = 90;

    typedef struct packed {
        t_status status;
        t_route  route;
    } t_answer;

    typedef struct {
        t_cmd   cmd;
        int     len;
        int     seed;
        t_route entry;
        logic   known;
        t_answer ans;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    snrt_req_if req_ch();
    snrt_rsp_if rsp_ch();

    stream_name_hash_route_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Behavioral copy of the table state.
    logic              slot_used [SLOT_COUNT];
    t_route            slot_route [SLOT_COUNT];
    logic [7:0]        stored_name [MAX_ROUTES][MAX_NAME_BYTES];
    int                stored_len [MAX_ROUTES];
    logic [7:0]        key_bytes [MAX_NAME_BYTES];
    logic [63:0]       name_hash;
    int                key_len;
    logic              key_overflow;

    t_answer           answers_due[$];
    int                error_count = 0;
    int                idle_cycles = 0;
    logic              timed_out = 1'b0;
    logic              hold_rsp = 1'b0;
    logic              stimulus_done = 1'b0;

    // Receiver pacing: answers taken so far and the wait drawn for the next.
    int                rsp_seen = 0;
    int                rsp_handled = 0;
    int                rsp_gap = 0;

    // Pool of names reused by the random part.
    logic [7:0]        pool_bytes [16][MAX_NAME_BYTES];
    int                pool_len [16];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void clear_key();
        name_hash    = FNV_BASIS;
        key_len      = 0;
        key_overflow = 1'b0;
    endfunction

    function automatic logic key_equals(input t_route r);
        if (r >= MAX_ROUTES || stored_len[r] != key_len) return 1'b0;
        for (int i = 0; i < key_len; i++)
            if (stored_name[r][i] != key_bytes[i]) return 1'b0;
        return 1'b1;
    endfunction

    // Advance the predicted table by one byte; return 1 with an answer on last.
    function automatic logic predict_route(input t_cmd cmd, input logic [7:0] b,
                                           input logic lst, input t_route entry,
                                           output t_answer ans);
        int  slot;
        logic done;
        name_hash = (name_hash ^ {56'd0, b}) * FNV_PRIME;
        if (key_len < MAX_NAME_BYTES) begin
            key_bytes[key_len] = b;
            key_len++;
        end else begin
            key_overflow = 1'b1;
        end
        if (!lst) return 1'b0;
        ans.route = '0;
        done = 1'b0;
        if (key_overflow) begin
            ans.status = ST_TOO_LONG;
        end else if (cmd == CMD_INSERT && entry >= MAX_ROUTES) begin
            ans.status = ST_FULL;
        end else begin
            slot = int'(name_hash % SLOT_COUNT);
            ans.status = (cmd == CMD_INSERT) ? ST_FULL : ST_UNKNOWN;
            for (int p = 0; p < SLOT_COUNT && !done; p++) begin
                if (!slot_used[slot]) begin
                    if (cmd == CMD_INSERT) begin
                        slot_used[slot]  = 1'b1;
                        slot_route[slot] = entry;
                        for (int i = 0; i < key_len; i++)
                            stored_name[entry][i] = key_bytes[i];
                        stored_len[entry] = key_len;
                        ans.status = ST_INSERTED;
                        ans.route  = entry;
                    end else begin
                        ans.status = ST_UNKNOWN;
                    end
                    done = 1'b1;
                end else if (key_equals(slot_route[slot])) begin
                    if (cmd == CMD_INSERT) begin
                        ans.status = ST_DUPLICATE;
                    end else begin
                        ans.status = ST_FOUND;
                        ans.route  = slot_route[slot];
                    end
                    done = 1'b1;
                end else begin
                    slot = (slot + 1) % SLOT_COUNT;
                end
            end
        end
        clear_key();
        return 1'b1;
    endfunction

    // Offer one request after a random gap; hold until accepted. Called at a
    // falling edge, and returns at the falling edge after the handshake.
    task automatic send_byte(input t_cmd cmd, input logic [7:0] b, input logic lst,
                             input t_route entry, input logic has_typed,
                             input t_answer typed);
        t_answer ans;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 1) == 0) gap = 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.command     <= cmd;
        req_ch.name_byte   <= b;
        req_ch.last        <= lst;
        req_ch.entry_index <= entry;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        if (predict_route(cmd, b, lst, entry, ans)) begin
            if (has_typed && ans != typed) begin
                report_mismatch("typed status", typed.status, ans.status);
                report_mismatch("typed route", typed.route, ans.route);
            end
            answers_due = {answers_due, (has_typed ? typed : ans)};
        end
        @(negedge i_clk);
    endtask

    // Send a name built from a seed pattern of the given length.
    task automatic send_name(input t_cmd cmd, input int len, input int seed,
                             input t_route entry, input logic has_typed,
                             input t_answer typed);
        for (int i = 0; i < len; i++)
            send_byte(cmd, 8'((seed * 7 + i * 13 + (i * i)) ^ seed), i == len - 1,
                      entry, has_typed, typed);
    endtask

    task automatic send_pool(input t_cmd cmd, input int k, input t_route entry);
        t_answer none;
        none = '0;
        for (int i = 0; i < pool_len[k]; i++)
            send_byte(cmd, pool_bytes[k][i], i == pool_len[k] - 1, entry, 1'b0, none);
    endtask

    // Drop valid and wait until every answer has come.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (answers_due.size() != 0 && !timed_out);
    endtask

    // Response side: after each taken answer hold ready low for a randomly drawn
    // wait, which may be none; hold ready low during a long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_rsp) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_handled != rsp_seen) begin
            rsp_handled = rsp_seen;
            rsp_gap = $urandom_range(0, 19);
            rsp_ch.ready <= (rsp_gap == 0);
        end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= (rsp_gap == 0);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Check each taken answer against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected answer", rsp_ch.status, -1);
            end else begin
                want = answers_due.pop_front();
                if (rsp_ch.status != want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.route_id != want.route)
                    report_mismatch("route id", rsp_ch.route_id, want.route);
            end
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out <= 1'b1;
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_answer mk(input t_status s, input t_route r);
        mk.status = s;
        mk.route  = r;
    endfunction

    initial begin
        t_dir_row rows [15];
        t_answer  none;
        int k;
        none = '0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_LOOKUP;
        req_ch.name_byte = '0;
        req_ch.last = 1'b0;
        req_ch.entry_index = '0;
        rsp_ch.ready = 1'b0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            slot_used[s] = 1'b0;
            slot_route[s] = '0;
        end
        for (int r = 0; r < MAX_ROUTES; r++) stored_len[r] = 0;
        clear_key();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows: typed answers where obvious, else predicted.
        rows[0]  = '{CMD_LOOKUP, 1, 3, 5'd0, 1'b1, mk(ST_UNKNOWN, 5'd0)};
        rows[1]  = '{CMD_INSERT, 1, 3, 5'd0, 1'b1, mk(ST_INSERTED, 5'd0)};
        rows[2]  = '{CMD_LOOKUP, 1, 3, 5'd9, 1'b1, mk(ST_FOUND, 5'd0)};
        rows[3]  = '{CMD_INSERT, 1, 3, 5'd5, 1'b1, mk(ST_DUPLICATE, 5'd0)};
        rows[4]  = '{CMD_INSERT, MAX_NAME_BYTES, 11, 5'd31, 1'b1, mk(ST_INSERTED, 5'd31)};
        rows[5]  = '{CMD_LOOKUP, MAX_NAME_BYTES, 11, 5'd0, 1'b1, mk(ST_FOUND, 5'd31)};
        rows[6]  = '{CMD_LOOKUP, MAX_NAME_BYTES + 1, 11, 5'd0, 1'b1,
                     mk(ST_TOO_LONG, 5'd0)};
        rows[7]  = '{CMD_INSERT, MAX_NAME_BYTES + 3, 12, 5'd4, 1'b1,
                     mk(ST_TOO_LONG, 5'd0)};
        rows[8]  = '{CMD_INSERT, 5, 20, 5'd7, 1'b0, none};
        rows[9]  = '{CMD_INSERT, 6, 21, 5'd7, 1'b0, none};   // route reuse
        rows[10] = '{CMD_LOOKUP, 5, 20, 5'd0, 1'b0, none};
        rows[11] = '{CMD_LOOKUP, 6, 21, 5'd0, 1'b0, none};
        rows[12] = '{CMD_INSERT, 2, 30, 5'd15, 1'b0, none};
        rows[13] = '{CMD_LOOKUP, 2, 31, 5'd0, 1'b0, none};
        rows[14] = '{CMD_INSERT, 3, 40, 5'd16, 1'b0, none};
        foreach (rows[i])
            send_name(rows[i].cmd, rows[i].len, rows[i].seed, rows[i].entry,
                      rows[i].known, rows[i].ans);
        // Full byte range, every bit both ways.
        send_byte(CMD_INSERT, 8'hFF, 1'b0, 5'd1, 1'b0, none);
        send_byte(CMD_INSERT, 8'h00, 1'b0, 5'd1, 1'b0, none);
        send_byte(CMD_INSERT, 8'hA5, 1'b1, 5'd1, 1'b0, none);
        send_byte(CMD_LOOKUP, 8'hFF, 1'b0, 5'd0, 1'b0, none);
        send_byte(CMD_LOOKUP, 8'h00, 1'b0, 5'd0, 1'b0, none);
        send_byte(CMD_LOOKUP, 8'hA5, 1'b1, 5'd0, 1'b0, none);

        // Long receiver hold-off while the sender keeps offering bytes.
        fork
            begin
                hold_rsp <= 1'b1;
                repeat (400) @(negedge i_clk);
                hold_rsp <= 1'b0;
            end
            begin
                for (int i = 0; i < 8; i++) send_name(CMD_LOOKUP, 2, i, 5'd0, 1'b0, none);
                wait_drained();
            end
        join
        wait_drained();

        for (int p = 0; p < 16; p++) begin
            pool_len[p] = (p == 15) ? MAX_NAME_BYTES : $urandom_range(1, 8);
            for (int i = 0; i < MAX_NAME_BYTES; i++) pool_bytes[p][i] = 8'($urandom);
        end

        // Random names: mostly pool reuse, some fresh or oversized ones.
        for (int n = 0; n < RANDOM_NAMES && !timed_out; n++) begin
            k = $urandom_range(0, 9);
            if (k < 7) begin
                send_pool(t_cmd'($urandom_range(0, 1)), $urandom_range(0, 15),
                          t_route'($urandom_range(0, 31)));
            end else begin
                int len;
                t_cmd c;
                t_route e;
                len = (k == 9) ? $urandom_range(60, 70) : $urandom_range(1, 6);
                c = t_cmd'($urandom_range(0, 1));
                e = t_route'($urandom_range(0, 31));
                for (int i = 0; i < len; i++)
                    send_byte(c, 8'($urandom), i == len - 1, e, 1'b0, none);
            end
            // Sender pause until the table has answered everything.
            if (n == RANDOM_NAMES / 2) wait_drained();
        end

        wait_drained();
        repeat (400) @(negedge i_clk);
        if (error_count == 0 && answers_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
